>>> sv/fmu_pkg.sv
// Package for the binary32 multiplier unit: field widths, constants and
// the pipeline stage record types. No dependencies.
package fmu_pkg;
    localparam int EXP_W  = 8;
    localparam int MANT_W = 23;
    localparam int SIG_W  = 24;
    localparam int PROD_W = 48;
    localparam logic [EXP_W-1:0]  EXP_MAX  = 8'hFF;
    localparam logic [9:0]        EXP_BIAS = 10'd127;
    localparam logic [MANT_W-1:0] QNAN_BIT = 23'h400000;
    localparam logic [MANT_W-1:0] NAN_MANT = 23'h000001;

    // Stage 1 record: special results resolved, significands ready.
    typedef struct packed {
        logic              sign;
        logic              special;
        logic [31:0]       special_word;
        logic signed [9:0] expo;
        logic [SIG_W-1:0]  ma;
        logic [SIG_W-1:0]  mb;
    } t_s1;

    // Stage 2 record: partial products.
    typedef struct packed {
        logic              sign;
        logic              special;
        logic [31:0]       special_word;
        logic signed [9:0] expo;
        logic [PROD_W-1:0] lo;   // ma * mb[11:0]
        logic [PROD_W-1:0] hi;   // ma * mb[23:12]
    } t_s2;

    // Stage 3 record: full product.
    typedef struct packed {
        logic              sign;
        logic              special;
        logic [31:0]       special_word;
        logic signed [9:0] expo;
        logic [PROD_W-1:0] p;
    } t_s3;
endpackage

>>> sv/float32_multiplier_unit.sv
// Top level of the binary32 multiplier unit: a five-stage pipeline.
// Depends on fmu_pkg.
//
// This unit multiplies two IEEE 754 single-precision words and returns the
// product truncated toward zero, with no rounding. It accepts one transaction
// every cycle while the output register is free or being taken. Stages: operand
// decode and special cases, split 24x12 partial products, product sum,
// normalization, subnormal shift and packing. A stall on the output freezes the
// whole pipeline while the output register holds a product, so nothing is lost
// or repeated; while the output register is empty a new transaction still enters
// even if the output stalls.
module float32_multiplier_unit
    import fmu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_product
);
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    t_s1 r_s1, n_s1;
    t_s2 r_s2, n_s2;
    t_s3 r_s3, n_s3;
    logic              r_sign4, r_special4;
    logic [31:0]       r_word4;
    logic signed [10:0] r_expo4;
    logic [SIG_W-1:0]  r_m4;
    logic              r_zero4;
    logic [31:0]       r_out, n_out;
    logic [PROD_W-1:0] n_m_full;
    logic signed [10:0] n_expo4;
    logic              n_zero4;
    logic              adv;

    // The pipeline moves whenever the output register is free or being taken.
    assign adv     = !r_v5 || !i_stall;
    assign o_stall = !adv;

    // Stage 1: decode and special-case resolution.
    always_comb begin
        logic [EXP_W-1:0] ea, eb;
        logic [MANT_W-1:0] fa, fb;
        logic nan_a, nan_b, snan_a, snan_b, inf_a, inf_b, zero_a, zero_b, sign;
        logic signed [9:0] e;
        ea = i_operand_a[30:23]; eb = i_operand_b[30:23];
        fa = i_operand_a[22:0];  fb = i_operand_b[22:0];
        sign   = i_operand_a[31] ^ i_operand_b[31];
        nan_a  = (ea == EXP_MAX) && (fa != '0);
        nan_b  = (eb == EXP_MAX) && (fb != '0);
        snan_a = nan_a && (fa < QNAN_BIT);
        snan_b = nan_b && (fb < QNAN_BIT);
        inf_a  = (ea == EXP_MAX) && (fa == '0);
        inf_b  = (eb == EXP_MAX) && (fb == '0);
        zero_a = (ea == '0) && (fa == '0);
        zero_b = (eb == '0) && (fb == '0);
        e = $signed({2'b00, ea}) + $signed({2'b00, eb}) - $signed(EXP_BIAS);
        n_s1.sign = sign;
        n_s1.special = 1'b1;
        n_s1.special_word = {sign, 8'h00, 23'h0};
        if (nan_a || nan_b) begin
            if (snan_a)      n_s1.special_word = {sign, ea, fa};
            else if (snan_b) n_s1.special_word = {sign, eb, fb};
            else             n_s1.special_word = {sign, EXP_MAX, NAN_MANT};
        end else if (inf_a || inf_b) begin
            if ((inf_a && zero_b) || (inf_b && zero_a))
                n_s1.special_word = {sign, EXP_MAX, NAN_MANT};
            else
                n_s1.special_word = {sign, EXP_MAX, 23'h0};
        end else if (e >= 10'sd255) begin
            n_s1.special_word = {sign, EXP_MAX, 23'h0};
        end else if (e < 10'sd0) begin
            n_s1.special_word = {sign, 8'h00, 23'h0};
        end else begin
            n_s1.special = 1'b0;
        end
        n_s1.expo = e + ((ea == '0) ? 10'sd1 : 10'sd0) + ((eb == '0) ? 10'sd1 : 10'sd0);
        n_s1.ma = {(ea != '0), fa};
        n_s1.mb = {(eb != '0), fb};
    end

    // Stage 2: two 24x12 partial products.
    always_comb begin
        n_s2.sign = r_s1.sign;
        n_s2.special = r_s1.special;
        n_s2.special_word = r_s1.special_word;
        n_s2.expo = r_s1.expo;
        n_s2.lo = {24'h0, r_s1.ma} * {36'h0, r_s1.mb[11:0]};
        n_s2.hi = {24'h0, r_s1.ma} * {36'h0, r_s1.mb[23:12]};
    end

    // Stage 3: sum of the partial products.
    always_comb begin
        n_s3.sign = r_s2.sign;
        n_s3.special = r_s2.special;
        n_s3.special_word = r_s2.special_word;
        n_s3.expo = r_s2.expo;
        n_s3.p = r_s2.lo + {r_s2.hi[PROD_W-13:0], 12'h0};
    end

    // Stage 4: normalize so that the significand fits in 24 bits.
    always_comb begin
        int k;
        k = 0;
        for (int i = PROD_W - 1; i >= SIG_W; i--) begin
            if (r_s3.p[i] && k == 0) k = i - SIG_W + 1;
        end
        n_m_full = r_s3.p >> k;
        n_expo4 = 11'(r_s3.expo) + 11'(k) - 11'sd23;
        n_zero4 = (r_s3.p == '0);
    end

    // Stage 5: special results, zero, overflow, subnormal shift and packing.
    always_comb begin
        logic [SIG_W-1:0] m;
        logic signed [11:0] sh;
        m = r_m4;
        sh = '0;
        n_out = {r_sign4, 8'h00, 23'h0};
        if (r_special4) begin
            n_out = r_word4;
        end else if (r_zero4) begin
            n_out = {r_sign4, 8'h00, 23'h0};
        end else if (r_expo4 >= 11'sd255) begin
            n_out = {r_sign4, EXP_MAX, 23'h0};
        end else if (r_expo4 <= 11'sd0) begin
            sh = 12'sd1 - 12'(r_expo4);
            m = (sh >= 12'sd24) ? '0 : (r_m4 >> sh[4:0]);
            n_out = {r_sign4, 8'h00, m[22:0]};
        end else begin
            n_out = {r_sign4, r_expo4[7:0], m[22:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0; r_v2 <= 1'b0; r_v3 <= 1'b0; r_v4 <= 1'b0; r_v5 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_valid; r_v2 <= r_v1; r_v3 <= r_v2; r_v4 <= r_v3; r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_s1 <= n_s1;
            r_s2 <= n_s2;
            r_s3 <= n_s3;
            r_sign4 <= r_s3.sign;
            r_special4 <= r_s3.special;
            r_word4 <= r_s3.special_word;
            r_expo4 <= n_expo4;
            r_m4 <= n_m_full[SIG_W-1:0];
            r_zero4 <= n_zero4;
            r_out <= n_out;
        end
    end

    assign o_valid   = r_v5;
    assign o_product = r_out;
endmodule
